@@ rtl/core/dpbt_pkg.sv @@
// Package for the depth pixel backprojection and rigid transform block.
// Holds field widths, derived datapath widths, register indexes and limits.
// No dependencies.
package dpbt_pkg;

  // Pixel coordinate and depth map dimension width
  localparam int COORD_W = 12;
  // Color address width and its saturation value
  localparam int COLOR_W = 12;
  localparam logic [COLOR_W-1:0] COLOR_MAX = '1;

  // Input depth, unsigned Q9.14; valid depths are above 0 and below 500.0
  localparam int DEPTH_W = 23;
  localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = DEPTH_W'(500 << 14);

  // Configuration register widths
  localparam int ROT_W      = 20;              // one Q2.18 rotation entry
  localparam int ROW_W      = 3 * ROT_W;       // one packed rotation row
  localparam int TR_W       = 21;              // one Q13.8 translation entry
  localparam int TRANS_W    = 3 * TR_W;
  localparam int INVF_W     = 32;              // inverse focal, Q0.32
  localparam int DIMS_W     = 2 * COORD_W;
  localparam int RATIO_W    = 24;              // Q8.16 color ratio
  localparam int SCALE_W    = 2 * RATIO_W;
  localparam int CFG_DATA_W = TRANS_W;         // widest register
  localparam int CFG_IDX_W  = 3;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_ROW0  = 3'd0,
    REG_ROT_ROW1  = 3'd1,
    REG_ROT_ROW2  = 3'd2,
    REG_TRANS     = 3'd3,
    REG_INV_FOCAL = 3'd4,
    REG_DEPTH_DIM = 3'd5,
    REG_COLOR_SCL = 3'd6
  } cfg_reg_e;

  // Backprojection datapath widths
  localparam int OFF_W  = COORD_W + 1;             // |2*coord - dim|
  localparam int M_W    = OFF_W + DEPTH_W;         // |offset| * depth
  localparam int HALF_W = INVF_W / 2;              // inverse focal halves
  localparam int PP_W   = M_W + HALF_W;            // partial products
  localparam int SUM_W  = M_W + INVF_W + 1;        // full product plus round
  localparam int RSH    = INVF_W + 1;              // final scale 2^-33
  localparam int MAG_W  = SUM_W - RSH;
  localparam int X_W    = MAG_W + 1;               // signed camera x, y

  // Transform datapath widths
  localparam int PROD_W = ROT_W + X_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int ACC_SH = 20;                      // Q.32 to Q.12
  localparam int SH_W   = ACC_W - ACC_SH;
  localparam int PT_W   = 36;                      // output Q24.12
  localparam int V_W    = ((SH_W > PT_W) ? SH_W : PT_W) + 1;

  // Color address datapath widths
  localparam int CP_W   = COORD_W + RATIO_W;
  localparam int CSH    = 16;
  localparam int CR_W   = CP_W + 1 - CSH;

endpackage

@@ rtl/core/depth_pixel_backproject_transform.sv @@
// Depth pixel backprojection through a pinhole model followed by a rigid
// transform, plus color pixel address scaling. Seven-stage pipeline.
// Depends on dpbt_pkg.
//
// Usage:
//   Input requests: drive pixel_row_i, pixel_col_i and depth_value_i with
//   start high; the request is taken at the clock edge where start is high
//   and busy is low. busy stays low, so a request may be issued every cycle.
//   Results: a request whose depth is above zero and below 500.0 produces one
//   result, registered through stages s1 to s6 and the output stage: done_o
//   is high for exactly one cycle together with point_x_o/y_o/z_o and
//   color_row_o/col_o. Other depths produce nothing. Requests leave in the
//   order they came in. Throughput is one request per cycle; the pipeline
//   depth comes from the two-step split of the 36x32 inverse focal multiply
//   and the rotation multiply and sum stages.
//   The receiver cannot stall: every result is presented once and is gone.
//   Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//   cfg_ready_o is always high. Write only while no request is in flight.
//   Reset (rst_ni low) clears the pipeline valid bits and loads the register
//   defaults: identity rotation, zero translation, inverse focal about 1/500,
//   480x640 depth map, unit color ratios.
module depth_pixel_backproject_transform
  import dpbt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input request
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_W-1:0]    pixel_row_i,
  input  logic [COORD_W-1:0]    pixel_col_i,
  input  logic [DEPTH_W-1:0]    depth_value_i,
  // Configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Results
  output logic                  done_o,
  output logic signed [PT_W-1:0] point_x_o,
  output logic signed [PT_W-1:0] point_y_o,
  output logic signed [PT_W-1:0] point_z_o,
  output logic [COLOR_W-1:0]    color_row_o,
  output logic [COLOR_W-1:0]    color_col_o
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [ROW_W-1:0]   rot_q [3];
  logic [TRANS_W-1:0] trans_q;
  logic [INVF_W-1:0]  inv_focal_q;
  logic [DIMS_W-1:0]  dims_q;
  logic [SCALE_W-1:0] scale_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0]    <= ROW_W'(64'd262144);
      rot_q[1]    <= ROW_W'(64'd274877906944);
      rot_q[2]    <= ROW_W'(64'd288230376151711744);
      trans_q     <= '0;
      inv_focal_q <= INVF_W'(64'd8589935);
      dims_q      <= DIMS_W'(64'd1966720);
      scale_q     <= SCALE_W'(64'd1099511693312);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ROT_ROW0:  rot_q[0]    <= cfg_data_i[ROW_W-1:0];
        REG_ROT_ROW1:  rot_q[1]    <= cfg_data_i[ROW_W-1:0];
        REG_ROT_ROW2:  rot_q[2]    <= cfg_data_i[ROW_W-1:0];
        REG_TRANS:     trans_q     <= cfg_data_i[TRANS_W-1:0];
        REG_INV_FOCAL: inv_focal_q <= cfg_data_i[INVF_W-1:0];
        REG_DEPTH_DIM: dims_q      <= cfg_data_i[DIMS_W-1:0];
        REG_COLOR_SCL: scale_q     <= cfg_data_i[SCALE_W-1:0];
        default: ;  // unused index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Valid bits: s1..s6 plus the output stage
  // ---------------------------------------------------------------------
  logic in_ok;
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q, s6_vld_q, done_q;

  assign in_ok = start && !busy && (depth_value_i != '0) &&
                 (depth_value_i < DEPTH_LIMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      s1_vld_q <= in_ok;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
      done_q   <= s6_vld_q;
    end
  end

  assign done_o = done_q;

  // ---------------------------------------------------------------------
  // Stage 1: offsets from the principal point, split into sign and size
  // Axis 0 is x (column), axis 1 is y (row).
  // ---------------------------------------------------------------------
  logic [COORD_W+1:0] off_c [2];
  logic [OFF_W-1:0]   s1_abs_q [2];
  logic               s1_neg_q [2];
  logic [DEPTH_W-1:0] s1_d_q;
  logic [COORD_W-1:0] s1_row_q, s1_col_q;

  always_comb begin
    off_c[0] = {1'b0, pixel_col_i, 1'b0} - {2'b00, dims_q[COORD_W-1:0]};
    off_c[1] = {1'b0, pixel_row_i, 1'b0} - {2'b00, dims_q[DIMS_W-1:COORD_W]};
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 2; a++) begin
      s1_neg_q[a] <= off_c[a][COORD_W+1];
      s1_abs_q[a] <= off_c[a][COORD_W+1] ? OFF_W'(~off_c[a] + 1'b1)
                                         : off_c[a][OFF_W-1:0];
    end
    s1_d_q   <= depth_value_i;
    s1_row_q <= pixel_row_i;
    s1_col_q <= pixel_col_i;
  end

  // ---------------------------------------------------------------------
  // Stage 2: |offset| * depth; color address products
  // ---------------------------------------------------------------------
  logic [M_W-1:0]     s2_m_q [2];
  logic               s2_neg_q [2];
  logic [DEPTH_W-1:0] s2_d_q;
  logic [CP_W-1:0]    s2_crow_q, s2_ccol_q;

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 2; a++) begin
      s2_m_q[a]   <= M_W'(s1_abs_q[a]) * M_W'(s1_d_q);
      s2_neg_q[a] <= s1_neg_q[a];
    end
    s2_d_q    <= s1_d_q;
    s2_crow_q <= CP_W'(s1_row_q) * CP_W'(scale_q[SCALE_W-1:RATIO_W]);
    s2_ccol_q <= CP_W'(s1_col_q) * CP_W'(scale_q[RATIO_W-1:0]);
  end

  // ---------------------------------------------------------------------
  // Stage 3: product by inverse focal in two halves; color rounding
  // ---------------------------------------------------------------------
  logic [PP_W-1:0]    s3_hi_q [2];
  logic [PP_W-1:0]    s3_lo_q [2];
  logic               s3_neg_q [2];
  logic [DEPTH_W-1:0] s3_d_q;
  logic [CR_W-1:0]    crow_c, ccol_c;
  logic [COLOR_W-1:0] s3_crow_q, s3_ccol_q;

  always_comb begin
    crow_c = CR_W'(((CP_W+1)'(s2_crow_q) + (CP_W+1)'(1 << (CSH - 1))) >> CSH);
    ccol_c = CR_W'(((CP_W+1)'(s2_ccol_q) + (CP_W+1)'(1 << (CSH - 1))) >> CSH);
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 2; a++) begin
      s3_hi_q[a]  <= PP_W'(s2_m_q[a]) * PP_W'(inv_focal_q[INVF_W-1:HALF_W]);
      s3_lo_q[a]  <= PP_W'(s2_m_q[a]) * PP_W'(inv_focal_q[HALF_W-1:0]);
      s3_neg_q[a] <= s2_neg_q[a];
    end
    s3_d_q    <= s2_d_q;
    // saturate scaled addresses beyond the color range
    s3_crow_q <= (crow_c[CR_W-1:COLOR_W] != '0) ? COLOR_MAX : crow_c[COLOR_W-1:0];
    s3_ccol_q <= (ccol_c[CR_W-1:COLOR_W] != '0) ? COLOR_MAX : ccol_c[COLOR_W-1:0];
  end

  // ---------------------------------------------------------------------
  // Stage 4: recombine halves, round half away from zero, apply sign
  // ---------------------------------------------------------------------
  logic [SUM_W-1:0]          sum_c [2];
  logic [X_W-1:0]            mag_c [2];
  logic signed [X_W-1:0]     s4_x_q [2];
  logic [DEPTH_W-1:0]        s4_d_q;
  logic [COLOR_W-1:0]        s4_crow_q, s4_ccol_q;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      sum_c[a] = SUM_W'({s3_hi_q[a], {HALF_W{1'b0}}}) + SUM_W'(s3_lo_q[a]) +
                 (SUM_W'(1) << (RSH - 1));
      mag_c[a] = {1'b0, sum_c[a][SUM_W-1:RSH]};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 2; a++) begin
      s4_x_q[a] <= s3_neg_q[a] ? (~mag_c[a] + 1'b1) : mag_c[a];
    end
    s4_d_q    <= s3_d_q;
    s4_crow_q <= s3_crow_q;
    s4_ccol_q <= s3_ccol_q;
  end

  // ---------------------------------------------------------------------
  // Stage 5: rotation products, nine in parallel
  // ---------------------------------------------------------------------
  logic signed [ROT_W-1:0]   rot_c [3][3];
  logic signed [DEPTH_W:0]   z_c;
  logic signed [PROD_W-1:0]  s5_p_q [3][3];
  logic [COLOR_W-1:0]        s5_crow_q, s5_ccol_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        rot_c[r][k] = rot_q[r][k*ROT_W +: ROT_W];
      end
    end
    z_c = {1'b0, s4_d_q};
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      s5_p_q[r][0] <= rot_c[r][0] * s4_x_q[0];
      s5_p_q[r][1] <= rot_c[r][1] * s4_x_q[1];
      s5_p_q[r][2] <= rot_c[r][2] * z_c;
    end
    s5_crow_q <= s4_crow_q;
    s5_ccol_q <= s4_ccol_q;
  end

  // ---------------------------------------------------------------------
  // Stage 6: row sums plus rounding bias for the Q.32 to Q.12 step
  // ---------------------------------------------------------------------
  logic signed [ACC_W-1:0] s6_acc_q [3];
  logic [COLOR_W-1:0]      s6_crow_q, s6_ccol_q;

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      s6_acc_q[r] <= {{2{s5_p_q[r][0][PROD_W-1]}}, s5_p_q[r][0]} +
                     {{2{s5_p_q[r][1][PROD_W-1]}}, s5_p_q[r][1]} +
                     {{2{s5_p_q[r][2][PROD_W-1]}}, s5_p_q[r][2]} +
                     (ACC_W'(1) << (ACC_SH - 1));
    end
    s6_crow_q <= s5_crow_q;
    s6_ccol_q <= s5_ccol_q;
  end

  // ---------------------------------------------------------------------
  // Stage 7: floor shift, add translation, saturate to the output range
  // ---------------------------------------------------------------------
  logic [SH_W-1:0]       sh_c [3];
  logic [TR_W-1:0]       tr_c [3];
  logic [V_W-1:0]        v_c [3];
  logic                  ovf_c [3];
  logic [PT_W-1:0]       pt_c [3];
  logic [PT_W-1:0]       pt_q [3];
  logic [COLOR_W-1:0]    crow_q, ccol_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sh_c[r]  = s6_acc_q[r][ACC_W-1:ACC_SH];
      tr_c[r]  = trans_q[r*TR_W +: TR_W];
      v_c[r]   = {{(V_W-SH_W){sh_c[r][SH_W-1]}}, sh_c[r]} +
                 {{(V_W-TR_W-4){tr_c[r][TR_W-1]}}, tr_c[r], 4'b0000};
      ovf_c[r] = v_c[r][V_W-1:PT_W-1] != {(V_W-PT_W+1){v_c[r][V_W-1]}};
      pt_c[r]  = ovf_c[r] ? {v_c[r][V_W-1], {(PT_W-1){~v_c[r][V_W-1]}}}
                          : v_c[r][PT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      pt_q[r] <= pt_c[r];
    end
    crow_q <= s6_crow_q;
    ccol_q <= s6_ccol_q;
  end

  assign point_x_o   = pt_q[0];
  assign point_y_o   = pt_q[1];
  assign point_z_o   = pt_q[2];
  assign color_row_o = crow_q;
  assign color_col_o = ccol_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // every result traces back to an earlier in-range request
  a_done_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy && (depth_value_i != '0) &&
                     (depth_value_i < DEPTH_LIMIT), 7))
    else $error("result without a matching request");

  // every in-range request produces its result
  a_request_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (depth_value_i != '0) && (depth_value_i < DEPTH_LIMIT))
      |-> ##7 done_o)
    else $error("in-range request lost in the pipeline");

  // out-of-range depths never reach the first stage
  a_reject_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && ((depth_value_i == '0) || (depth_value_i >= DEPTH_LIMIT)))
      |=> !s1_vld_q)
    else $error("out-of-range depth entered the pipeline");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for depth_pixel_backproject_transform: sends depth pixel requests and
// register writes, predicts each transformed point and color address, and checks them.
// Depends on dpbt_pkg and the block's RTL.
module tb_top
  import dpbt_pkg::*;
();

  localparam int LATENCY       = 7;
  localparam int SETTLE_CYCLES = LATENCY + 4;
  localparam int MAX_CYCLES    = 200000;
  localparam int REPORT_LIMIT  = 10;
  localparam int ITEMS_PER_CFG = 130;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam longint PT_MAX = 64'sd34359738367;
  localparam longint PT_MIN = -64'sd34359738368;
  localparam logic [ROT_W-1:0] ROT_ONE   = 20'h40000;   // 1.0 in Q2.18
  localparam logic [RATIO_W-1:0] RATIO_ONE = 24'h010000; // 1.0 in Q8.16

  typedef struct {
    logic signed [PT_W-1:0] x;
    logic signed [PT_W-1:0] y;
    logic signed [PT_W-1:0] z;
    logic [COLOR_W-1:0]     crow;
    logic [COLOR_W-1:0]     ccol;
  } point_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  logic [COORD_W-1:0] pixel_row_i;
  logic [COORD_W-1:0] pixel_col_i;
  logic [DEPTH_W-1:0] depth_value_i;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic done_o;
  logic signed [PT_W-1:0] point_x_o;
  logic signed [PT_W-1:0] point_y_o;
  logic signed [PT_W-1:0] point_z_o;
  logic [COLOR_W-1:0] color_row_o;
  logic [COLOR_W-1:0] color_col_o;

  // Shadow copy of the register file
  logic [ROW_W-1:0]   rot_q [3];
  logic [TRANS_W-1:0] trans_q;
  logic [INVF_W-1:0]  invf_q;
  logic [DIMS_W-1:0]  dims_q;
  logic [SCALE_W-1:0] scale_q;

  point_t pending_points[$];
  int mismatches;
  int sender_idle_pct;
  int unsigned cycle_count = 0;

  depth_pixel_backproject_transform DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .pixel_row_i  (pixel_row_i),
    .pixel_col_i  (pixel_col_i),
    .depth_value_i(depth_value_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .done_o       (done_o),
    .point_x_o    (point_x_o),
    .point_y_o    (point_y_o),
    .point_z_o    (point_z_o),
    .color_row_o  (color_row_o),
    .color_col_o  (color_col_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("depth_pixel_backproject_transform verification failed");
      $finish;
    end
  end

  // Camera-space coordinate: round(off2 * d * invf / 2^33), ties away from zero
  function automatic longint camera_coord(logic [COORD_W-1:0] coord,
                                          logic [COORD_W-1:0] dim,
                                          logic [DEPTH_W-1:0] depth);
    longint off2;
    longint mag;
    logic [71:0] amag;
    logic [71:0] prod;
    off2 = 2 * $signed({52'd0, coord}) - $signed({52'd0, dim});
    amag = 72'((off2 < 0) ? -off2 : off2);
    prod = amag * depth * invf_q + (72'd1 << 32);
    mag = longint'(prod >> 33);
    return (off2 < 0) ? -mag : mag;
  endfunction

  // One rotation row dot product, rounded to Q.12, plus translation, saturated
  function automatic logic signed [PT_W-1:0] rotate_translate(logic [ROW_W-1:0] row,
                                                              longint x, longint y,
                                                              longint z,
                                                              logic [TR_W-1:0] tr);
    longint acc;
    longint v;
    acc = longint'($signed(row[ROT_W-1:0])) * x
        + longint'($signed(row[2*ROT_W-1:ROT_W])) * y
        + longint'($signed(row[3*ROT_W-1:2*ROT_W])) * z;
    v = (acc + (64'sd1 <<< 19)) >>> ACC_SH;
    v = v + longint'($signed(tr)) * 16;
    if (v > PT_MAX) v = PT_MAX;
    if (v < PT_MIN) v = PT_MIN;
    return v[PT_W-1:0];
  endfunction

  // Nearest color address, saturated at the top
  function automatic logic [COLOR_W-1:0] scale_color(logic [COORD_W-1:0] c,
                                                     logic [RATIO_W-1:0] ratio);
    logic [CP_W:0] p;
    p = (c * ratio + 37'h8000) >> CSH;
    return (p > COLOR_MAX) ? COLOR_MAX : p[COLOR_W-1:0];
  endfunction

  // Expected result of one pixel; returns 0 where the depth gives none
  function automatic bit predict_pixel(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                                       logic [DEPTH_W-1:0] depth, output point_t pt);
    longint x;
    longint y;
    longint z;
    if (depth == '0 || depth >= DEPTH_LIMIT) return 1'b0;
    x = camera_coord(col, dims_q[COORD_W-1:0], depth);
    y = camera_coord(row, dims_q[DIMS_W-1:COORD_W], depth);
    z = longint'(depth);
    pt.x = rotate_translate(rot_q[0], x, y, z, trans_q[TR_W-1:0]);
    pt.y = rotate_translate(rot_q[1], x, y, z, trans_q[2*TR_W-1:TR_W]);
    pt.z = rotate_translate(rot_q[2], x, y, z, trans_q[3*TR_W-1:2*TR_W]);
    pt.crow = scale_color(row, scale_q[SCALE_W-1:RATIO_W]);
    pt.ccol = scale_color(col, scale_q[RATIO_W-1:0]);
    return 1'b1;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[CFG_DATA_W-1:0];
  endfunction

  // Packed rotation row; bits above the row are random and must be dropped
  function automatic logic [CFG_DATA_W-1:0] rot_word(logic [ROT_W-1:0] e0,
                                                     logic [ROT_W-1:0] e1,
                                                     logic [ROT_W-1:0] e2);
    logic [CFG_DATA_W-1:0] w;
    w = rand_word();
    return {w[CFG_DATA_W-1:ROW_W], e2, e1, e0};
  endfunction

  // Result checker: every done pulse is matched against the oldest expectation
  always @(posedge clk_i) begin
    point_t exp_pt;
    if (rst_ni && done_o) begin
      if (pending_points.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("unexpected result: x=%0d y=%0d z=%0d row=%0d col=%0d",
                   point_x_o, point_y_o, point_z_o, color_row_o, color_col_o);
        mismatches++;
      end else begin
        exp_pt = pending_points.pop_front();
        if (point_x_o !== exp_pt.x || point_y_o !== exp_pt.y || point_z_o !== exp_pt.z ||
            color_row_o !== exp_pt.crow || color_col_o !== exp_pt.ccol) begin
          if (mismatches < REPORT_LIMIT) begin
            $display("mismatch: expected x=%0d y=%0d z=%0d row=%0d col=%0d",
                     exp_pt.x, exp_pt.y, exp_pt.z, exp_pt.crow, exp_pt.ccol);
            $display("          actual   x=%0d y=%0d z=%0d row=%0d col=%0d",
                     point_x_o, point_y_o, point_z_o, color_row_o, color_col_o);
          end
          mismatches++;
        end
      end
    end
  end

  // Send one pixel request; start stays high for a following request
  task automatic send_pixel(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                            logic [DEPTH_W-1:0] depth);
    point_t pt;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start         <= 1'b1;
    pixel_row_i   <= row;
    pixel_col_i   <= col;
    depth_value_i <= depth;
    do @(posedge clk_i); while (busy);
    if (predict_pixel(row, col, depth, pt))
      pending_points.insert(pending_points.size(), pt);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain(int extra_cycles);
    start <= 1'b0;
    do @(posedge clk_i); while (pending_points.size() != 0);
    repeat (extra_cycles) @(posedge clk_i);
  endtask

  // Register write; shadow copy follows at the accepting edge
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_ROT_ROW0:  rot_q[0] = data[ROW_W-1:0];
      REG_ROT_ROW1:  rot_q[1] = data[ROW_W-1:0];
      REG_ROT_ROW2:  rot_q[2] = data[ROW_W-1:0];
      REG_TRANS:     trans_q  = data[TRANS_W-1:0];
      REG_INV_FOCAL: invf_q   = data[INVF_W-1:0];
      REG_DEPTH_DIM: dims_q   = data[DIMS_W-1:0];
      REG_COLOR_SCL: scale_q  = data[SCALE_W-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Depth bounds under the reset configuration
  task automatic test_depth_range();
    send_pixel(12'd240, 12'd320, 23'd16384);
    send_pixel(12'd100, 12'd600, 23'd1);
    send_pixel(12'd479, 12'd0, DEPTH_LIMIT - 1'b1);
    send_pixel(12'd0, 12'd0, 23'd0);
    send_pixel(12'd7, 12'd9, DEPTH_LIMIT);
    send_pixel(12'd4095, 12'd4095, '1);
  endtask

  // Pixel coordinate corners under the reset configuration
  task automatic test_coord_extremes();
    send_pixel(12'd0, 12'd0, 23'd16384);
    send_pixel(12'd4095, 12'd4095, 23'd16384);
    send_pixel(12'd0, 12'd4095, 23'd4000000);
    send_pixel(12'd4095, 12'd0, 23'd4000000);
  endtask

  // Largest gains and offsets: points saturate both ways, color saturates
  task automatic test_saturation();
    drain(SETTLE_CYCLES);
    write_reg(REG_ROT_ROW0, rot_word(20'h7FFFF, 20'h7FFFF, 20'h7FFFF));
    write_reg(REG_ROT_ROW1, rot_word(20'h7FFFF, 20'h7FFFF, 20'h7FFFF));
    write_reg(REG_ROT_ROW2, rot_word(20'h7FFFF, 20'h7FFFF, 20'h7FFFF));
    write_reg(REG_TRANS, {21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF});
    write_reg(REG_INV_FOCAL, CFG_DATA_W'(32'hFFFF_FFFF));
    write_reg(REG_DEPTH_DIM, '0);
    write_reg(REG_COLOR_SCL, CFG_DATA_W'({SCALE_W{1'b1}}));
    send_pixel(12'd4095, 12'd4095, DEPTH_LIMIT - 1'b1);
    send_pixel(12'd0, 12'd0, DEPTH_LIMIT - 1'b1);
    send_pixel(12'd1, 12'd1, 23'd1);
    drain(SETTLE_CYCLES);
    write_reg(REG_ROT_ROW0, rot_word(20'h80000, 20'h80000, 20'h80000));
    write_reg(REG_ROT_ROW1, rot_word(20'h80000, 20'h80000, 20'h80000));
    write_reg(REG_ROT_ROW2, rot_word(20'h80000, 20'h80000, 20'h80000));
    write_reg(REG_TRANS, {21'h100000, 21'h100000, 21'h100000});
    write_reg(REG_DEPTH_DIM, '1);
    send_pixel(12'd4095, 12'd4095, DEPTH_LIMIT - 1'b1);
    send_pixel(12'd0, 12'd0, DEPTH_LIMIT - 1'b1);
    send_pixel(12'd2047, 12'd2048, 23'd8000000);
  endtask

  // All-zero registers, zero depth dimensions, and a write to an unmapped index
  task automatic test_zero_config();
    drain(SETTLE_CYCLES);
    for (int r = 0; r <= REG_COLOR_SCL; r++) write_reg(CFG_IDX_W'(r), '0);
    send_pixel(12'd0, 12'd0, 23'd16384);
    send_pixel(12'd4095, 12'd4095, DEPTH_LIMIT - 1'b1);
    drain(SETTLE_CYCLES);
    write_reg(REG_ROT_ROW0, rot_word(ROT_ONE, '0, '0));
    write_reg(REG_ROT_ROW1, rot_word('0, ROT_ONE, '0));
    write_reg(REG_ROT_ROW2, rot_word('0, '0, ROT_ONE));
    write_reg(REG_INV_FOCAL, CFG_DATA_W'(32'd8589935));
    write_reg(REG_COLOR_SCL, CFG_DATA_W'({RATIO_ONE, RATIO_ONE}));
    send_pixel(12'd0, 12'd0, 23'd16384);
    send_pixel(12'd300, 12'd200, 23'd123456);
    // unmapped index leaves every register alone
    drain(SETTLE_CYCLES);
    write_reg(REG_UNMAPPED, '1);
    send_pixel(12'd300, 12'd200, 23'd123456);
  endtask

  // Either a camera-like setup or raw random register contents
  task automatic load_random_config(bit plausible);
    logic [ROT_W-1:0] e [9];
    if (plausible) begin
      foreach (e[k]) e[k] = ROT_W'($urandom_range(0, 2**19) - 2**18);
      write_reg(REG_ROT_ROW0, rot_word(e[0], e[1], e[2]));
      write_reg(REG_ROT_ROW1, rot_word(e[3], e[4], e[5]));
      write_reg(REG_ROT_ROW2, rot_word(e[6], e[7], e[8]));
      write_reg(REG_TRANS, rand_word());
      // focal length between about 50 and 4000 pixels
      write_reg(REG_INV_FOCAL, CFG_DATA_W'($urandom_range(1073742, 85899346)));
      write_reg(REG_DEPTH_DIM, CFG_DATA_W'({COORD_W'($urandom_range(1, 4095)),
                                            COORD_W'($urandom_range(1, 4095))}));
      write_reg(REG_COLOR_SCL, CFG_DATA_W'({RATIO_W'($urandom_range(0, 4 << 16)),
                                            RATIO_W'($urandom_range(0, 4 << 16))}));
    end else begin
      for (int r = 0; r <= REG_COLOR_SCL; r++) write_reg(CFG_IDX_W'(r), rand_word());
    end
  endtask

  // Random pixels, mostly valid depths, some out-of-range noise
  task automatic random_pixels(int count);
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [DEPTH_W-1:0] depth;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) depth = DEPTH_W'($urandom_range(1, DEPTH_LIMIT - 1));
      else if (pick < 90) depth = '0;
      else depth = DEPTH_W'($urandom_range(DEPTH_LIMIT, 2**DEPTH_W - 1));
      if ($urandom_range(0, 1)) begin
        row = COORD_W'($urandom_range(0, dims_q[DIMS_W-1:COORD_W]));
        col = COORD_W'($urandom_range(0, dims_q[COORD_W-1:0]));
      end else begin
        row = COORD_W'($urandom_range(0, 2**COORD_W - 1));
        col = COORD_W'($urandom_range(0, 2**COORD_W - 1));
      end
      // hold off until the pipeline has emptied now and then
      if (i == count / 2 || $urandom_range(0, 299) == 0) drain(0);
      send_pixel(row, col, depth);
    end
  endtask

  task automatic test_random_phase(int idle_pct);
    sender_idle_pct = idle_pct;
    for (int k = 0; k < 5; k++) begin
      drain(SETTLE_CYCLES);
      load_random_config(k != 2);
      random_pixels(ITEMS_PER_CFG);
    end
  endtask

  initial begin
    mismatches      = 0;
    sender_idle_pct = 36;
    rot_q[0] = ROW_W'(64'd262144);
    rot_q[1] = ROW_W'(64'd274877906944);
    rot_q[2] = ROW_W'(64'd288230376151711744);
    trans_q  = '0;
    invf_q   = 32'd8589935;
    dims_q   = {12'd480, 12'd640};
    scale_q  = {RATIO_ONE, RATIO_ONE};
    rst_ni        = 1'b0;
    start         = 1'b0;
    pixel_row_i   = '0;
    pixel_col_i   = '0;
    depth_value_i = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_depth_range();
    test_coord_extremes();
    test_saturation();
    test_zero_config();
    test_random_phase(36);
    test_random_phase(75);
    test_random_phase(0);

    drain(SETTLE_CYCLES);
    if (mismatches == 0) begin
      $display("depth_pixel_backproject_transform verification clean");
    end else begin
      $display("depth_pixel_backproject_transform verification failed");
    end
    $finish;
  end

endmodule

@@ depth_pixel_backproject_transform.f @@
rtl/core/dpbt_pkg.sv
rtl/core/depth_pixel_backproject_transform.sv
tb/tb_top.sv
